@@ hdl/ycbcr422_to_rgb_macros.svh @@
// Assertion macros for the 4:2:2 to RGB converter.
`ifndef YCBCR422_TO_RGB_MACROS_SVH
`define YCBCR422_TO_RGB_MACROS_SVH

`ifndef SYNTH
`define YCR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define YCR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define YCR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define YCR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/ycr_pkg.sv @@
package ycr_pkg;

    localparam int CFG_W         = 12;
    localparam int CFG_RESET     = 360;
    localparam int MAX_PAIRS_DEF = 2048;

    // Q16 scale and color coefficients
    localparam int K_LUMA   = 76309;
    localparam int K_CHROMA = 74605;
    localparam int K_RV     = 91920;
    localparam int K_GU     = 22570;
    localparam int K_GV     = 46818;
    localparam int K_BU     = 116195;

    // chroma scale folded into each coefficient (Q32)
    localparam logic [35:0] C_RV = 36'(K_RV) * 36'(K_CHROMA);
    localparam logic [35:0] C_GU = 36'(K_GU) * 36'(K_CHROMA);
    localparam logic [35:0] C_GV = 36'(K_GV) * 36'(K_CHROMA);
    localparam logic [35:0] C_BU = 36'(K_BU) * 36'(K_CHROMA);

    localparam int SUM_W = 44;
    localparam int FRAC_W = 32;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;

    typedef logic signed [SUM_W-1:0] t_sum;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       line_done;
        logic       run_last;
    } t_pix;

    function automatic logic [7:0] clip_q32(input t_sum s);
        logic [SUM_W-FRAC_W-1:0] t;
        t = s[SUM_W-1:FRAC_W];
        if (s[SUM_W-1]) begin
            return 8'd0;
        end else if (t >= (SUM_W-FRAC_W)'(255)) begin
            return 8'd255;
        end else begin
            return t[7:0];
        end
    endfunction

endpackage

@@ hdl/ycbcr422_to_rgb.sv @@
// 4:2:2 YCbCr to RGB converter (BT.601 coefficients).
// Input channel: i_valid / o_stall with i_chroma and i_luma, one pixel word per
// transfer. Even words of a line carry Cb, odd words carry Cr.
// Output channel: o_valid / i_stall with o_red, o_green, o_blue, o_line_done and
// o_run_last. An input word yields zero, one or two pixels; o_run_last marks the
// last pixel caused by a word, o_line_done the final pixel of a line.
// Config: i_cfg_wr_en / i_cfg_wr_data set pixel pairs per line (reset 360).
// Throughput: one input word per cycle while o_stall is low. An input transfer
// reaches the output through the job register, product register and output queue.
// An 8-entry output queue decouples the receiver; o_stall rises when the queue
// and the pixels in flight could not take two more results, so a stalled
// receiver backs the input up after a few words and nothing is lost.
// Reset (synchronous, active low) empties the queue, restarts the line at an
// even word with no pixel pending and reloads the pairs-per-line register.
`include "ycbcr422_to_rgb_macros.svh"

module ycbcr422_to_rgb
    import ycr_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_chroma,
    input  logic [7:0]       i_luma,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic             o_line_done,
    output logic             o_run_last
);

    localparam int W_IDX = $clog2(MAX_PAIRS);
    localparam int W_CMP = ($clog2(MAX_PAIRS + 1) > CFG_W) ? $clog2(MAX_PAIRS + 1) : CFG_W;

    // config and line state
    logic [CFG_W-1:0] r_ppl;
    logic             r_odd_phase, n_odd_phase;
    logic             r_odd_pending, n_odd_pending;
    logic [7:0]       r_held_cb, n_held_cb;
    logic [7:0]       r_held_cr, n_held_cr;
    logic [7:0]       r_held_luma, n_held_luma;
    logic [W_IDX-1:0] r_pair_idx, n_pair_idx;

    // job stage
    logic       r_j_vld, n_j_vld;
    logic       r_j_two, n_j_two;
    logic [7:0] r_j_y0, n_j_y0;
    logic [7:0] r_j_y1, n_j_y1;
    logic [7:0] r_j_cb, n_j_cb;
    logic [7:0] r_j_cr, n_j_cr;

    // product stage
    logic r_b_vld;
    logic r_b_two;
    t_sum r_b_y0, r_b_y1, r_b_rv, r_b_gu, r_b_gv, r_b_bu;

    // output queue
    t_pix               r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr, r_rptr;
    logic [FIFO_AW:0]   r_cnt;
    logic [FIFO_AW:0]   r_pend;

    logic             acc;
    logic [1:0]       acc_n;
    logic             out_xfer;
    logic [W_CMP-1:0] cfg_x, eff, idx_next;
    logic             line_end;

    logic signed [8:0] dy0, dy1, du, dv;
    t_pix              pix_a, pix_b;
    logic [1:0]        push_n;

    assign o_stall  = r_pend > (FIFO_AW+1)'(FIFO_DEPTH - 2);
    assign acc      = i_valid && !o_stall;
    assign o_valid  = r_cnt != '0;
    assign out_xfer = o_valid && !i_stall;

    assign cfg_x    = W_CMP'(r_ppl);
    assign idx_next = W_CMP'(r_pair_idx) + W_CMP'(1);
    assign line_end = idx_next >= eff;

    always_comb begin
        if (cfg_x == '0) begin
            eff = W_CMP'(1);
        end else if (cfg_x > W_CMP'(MAX_PAIRS)) begin
            eff = W_CMP'(MAX_PAIRS);
        end else begin
            eff = cfg_x;
        end
    end

    // word decode and job build
    always_comb begin
        n_odd_phase   = r_odd_phase;
        n_odd_pending = r_odd_pending;
        n_held_cb     = r_held_cb;
        n_held_cr     = r_held_cr;
        n_held_luma   = r_held_luma;
        n_pair_idx    = r_pair_idx;
        n_j_vld       = 1'b0;
        n_j_two       = 1'b0;
        n_j_y0        = r_held_luma;
        n_j_y1        = i_luma;
        n_j_cb        = r_held_cb;
        n_j_cr        = i_chroma;
        acc_n         = 2'd0;
        if (acc) begin
            if (!r_odd_phase) begin
                if (r_odd_pending) begin
                    n_j_vld       = 1'b1;
                    n_j_cb        = i_chroma;
                    n_j_cr        = r_held_cr;
                    acc_n         = 2'd1;
                    n_odd_pending = 1'b0;
                end
                n_held_cb   = i_chroma;
                n_held_luma = i_luma;
                n_odd_phase = 1'b1;
            end else begin
                n_odd_phase = 1'b0;
                n_j_vld     = 1'b1;
                if (line_end) begin
                    n_j_two       = 1'b1;
                    acc_n         = 2'd2;
                    n_pair_idx    = '0;
                    n_odd_pending = 1'b0;
                end else begin
                    acc_n         = 2'd1;
                    n_held_cr     = i_chroma;
                    n_held_luma   = i_luma;
                    n_odd_pending = 1'b1;
                    n_pair_idx    = r_pair_idx + W_IDX'(1);
                end
            end
        end
    end

    assign dy0 = $signed({1'b0, r_j_y0}) - 9'sd16;
    assign dy1 = $signed({1'b0, r_j_y1}) - 9'sd16;
    assign du  = $signed({1'b0, r_j_cb}) - 9'sd128;
    assign dv  = $signed({1'b0, r_j_cr}) - 9'sd128;

    // sums and clipping
    always_comb begin
        pix_a.red       = clip_q32(r_b_y0 + r_b_rv);
        pix_a.green     = clip_q32(r_b_y0 - r_b_gu - r_b_gv);
        pix_a.blue      = clip_q32(r_b_y0 + r_b_bu);
        pix_a.line_done = 1'b0;
        pix_a.run_last  = !r_b_two;
        pix_b.red       = clip_q32(r_b_y1 + r_b_rv);
        pix_b.green     = clip_q32(r_b_y1 - r_b_gu - r_b_gv);
        pix_b.blue      = clip_q32(r_b_y1 + r_b_bu);
        pix_b.line_done = 1'b1;
        pix_b.run_last  = 1'b1;
        push_n          = r_b_vld ? (r_b_two ? 2'd2 : 2'd1) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppl         <= CFG_W'(CFG_RESET);
            r_odd_phase   <= 1'b0;
            r_odd_pending <= 1'b0;
            r_held_cb     <= 8'd128;
            r_held_cr     <= 8'd128;
            r_held_luma   <= 8'd16;
            r_pair_idx    <= '0;
            r_j_vld       <= 1'b0;
            r_b_vld       <= 1'b0;
            r_wptr        <= '0;
            r_rptr        <= '0;
            r_cnt         <= '0;
            r_pend        <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_ppl <= i_cfg_wr_data;
            end
            r_odd_phase   <= n_odd_phase;
            r_odd_pending <= n_odd_pending;
            r_held_cb     <= n_held_cb;
            r_held_cr     <= n_held_cr;
            r_held_luma   <= n_held_luma;
            r_pair_idx    <= n_pair_idx;
            r_j_vld       <= n_j_vld;
            r_b_vld       <= r_j_vld;
            r_wptr        <= r_wptr + FIFO_AW'(push_n);
            r_rptr        <= r_rptr + FIFO_AW'(out_xfer);
            r_cnt         <= r_cnt + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(out_xfer);
            r_pend        <= r_pend + (FIFO_AW+1)'(acc_n) - (FIFO_AW+1)'(out_xfer);
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_j_two <= n_j_two;
        r_j_y0  <= n_j_y0;
        r_j_y1  <= n_j_y1;
        r_j_cb  <= n_j_cb;
        r_j_cr  <= n_j_cr;
        r_b_two <= r_j_two;
        r_b_y0  <= t_sum'(dy0 * $signed(SUM_W'(K_LUMA))) <<< 16;
        r_b_y1  <= t_sum'(dy1 * $signed(SUM_W'(K_LUMA))) <<< 16;
        r_b_rv  <= t_sum'(dv * $signed(SUM_W'(C_RV)));
        r_b_gu  <= t_sum'(du * $signed(SUM_W'(C_GU)));
        r_b_gv  <= t_sum'(dv * $signed(SUM_W'(C_GV)));
        r_b_bu  <= t_sum'(du * $signed(SUM_W'(C_BU)));
        if (r_b_vld) begin
            r_fifo[r_wptr] <= pix_a;
            if (r_b_two) begin
                r_fifo[r_wptr + FIFO_AW'(1)] <= pix_b;
            end
        end
    end

    assign o_red       = r_fifo[r_rptr].red;
    assign o_green     = r_fifo[r_rptr].green;
    assign o_blue      = r_fifo[r_rptr].blue;
    assign o_line_done = r_fifo[r_rptr].line_done;
    assign o_run_last  = r_fifo[r_rptr].run_last;

    `YCR_ASSERT_IMP(a_pend_bound, i_clk, i_rst_n, 1'b1, r_pend <= (FIFO_AW+1)'(FIFO_DEPTH))
    `YCR_ASSERT_IMP(a_cnt_le_pend, i_clk, i_rst_n, 1'b1, r_cnt <= r_pend)
    `YCR_ASSERT_IMP(a_pending_even, i_clk, i_rst_n, r_odd_pending, !r_odd_phase)
    `YCR_ASSERT_NXT(a_odd_job, i_clk, i_rst_n, acc && r_odd_phase, r_j_vld)

endmodule

@@ dv/tb_ycbcr422_to_rgb.sv @@
module tb_ycbcr422_to_rgb;
    import ycr_pkg::*;

    localparam int LIMIT       = 600000;
    localparam int MAX_GAP     = 12;
    localparam int HOLD_LEN    = 250;
    localparam int TAIL        = 12;
    localparam int MAX_REPORTS = 40;
    localparam int N_PHASES    = 12;

    class rgb_scoreboard;
        t_pix        pixel_q[$];
        int unsigned errors;
        int unsigned words_in;
        int unsigned pixels_out;
        int unsigned lines_done;
        logic [11:0] pairs_cfg;
        bit          odd_word;
        bit          odd_held;
        logic [7:0]  cb_h;
        logic [7:0]  cr_h;
        logic [7:0]  y_h;
        int unsigned pair_idx;

        function new();
            pairs_cfg = 12'(CFG_RESET);
            odd_word  = 1'b0;
            odd_held  = 1'b0;
            cb_h      = 8'd128;
            cr_h      = 8'd128;
            y_h       = 8'd16;
            pair_idx  = 0;
        endfunction

        function logic [7:0] clamp8(longint s);
            longint t;
            if (s < 0) return 8'd0;
            t = s >>> 32;
            if (t >= 255) return 8'd255;
            return t[7:0];
        endfunction

        function t_pix make_pix(logic [7:0] y8, logic [7:0] cb8, logic [7:0] cr8,
                                bit done, bit last);
            longint ys;
            longint u;
            longint v;
            t_pix   p;
            ys = y8;
            u  = cb8;
            v  = cr8;
            ys = (ys - 16) * K_LUMA * 65536;
            u  = (u - 128) * K_CHROMA;
            v  = (v - 128) * K_CHROMA;
            p.red       = clamp8(ys + longint'(K_RV) * v);
            p.green     = clamp8(ys - longint'(K_GU) * u - longint'(K_GV) * v);
            p.blue      = clamp8(ys + longint'(K_BU) * u);
            p.line_done = done;
            p.run_last  = last;
            return p;
        endfunction

        function void note_word(logic [7:0] chroma, logic [7:0] luma);
            int unsigned eff;
            eff = (pairs_cfg == 0) ? 1 :
                  (pairs_cfg > MAX_PAIRS_DEF) ? MAX_PAIRS_DEF : int'(pairs_cfg);
            words_in++;
            if (!odd_word) begin
                if (odd_held) begin
                    pixel_q.push_back(make_pix(y_h, chroma, cr_h, 1'b0, 1'b1));
                    odd_held = 1'b0;
                end
                cb_h     = chroma;
                y_h      = luma;
                odd_word = 1'b1;
            end else begin
                odd_word = 1'b0;
                if (pair_idx + 1 >= eff) begin
                    pixel_q.push_back(make_pix(y_h, cb_h, chroma, 1'b0, 1'b0));
                    pixel_q.push_back(make_pix(luma, cb_h, chroma, 1'b1, 1'b1));
                    pair_idx = 0;
                    odd_held = 1'b0;
                end else begin
                    pixel_q.push_back(make_pix(y_h, cb_h, chroma, 1'b0, 1'b1));
                    cr_h     = chroma;
                    y_h      = luma;
                    odd_held = 1'b1;
                    pair_idx++;
                end
            end
        endfunction

        function void report(string field, logic [7:0] want, logic [7:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: pixel %0d %s expected %0d actual %0d",
                         $time, pixels_out, field, want, got);
        endfunction

        function void check_pixel(t_pix got);
            t_pix want;
            if (pixel_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected pixel expected none actual %h", $time, got);
                return;
            end
            want = pixel_q.pop_front();
            pixels_out++;
            if (got.line_done === 1'b1) lines_done++;
            if (got.red !== want.red) report("red", want.red, got.red);
            if (got.green !== want.green) report("green", want.green, got.green);
            if (got.blue !== want.blue) report("blue", want.blue, got.blue);
            if (got.line_done !== want.line_done)
                report("line_done", 8'(want.line_done), 8'(got.line_done));
            if (got.run_last !== want.run_last)
                report("run_last", 8'(want.run_last), 8'(got.run_last));
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [CFG_W-1:0] i_cfg_wr_data;
    logic             i_valid;
    logic             o_stall;
    logic [7:0]       i_chroma;
    logic [7:0]       i_luma;
    logic             o_valid;
    logic             i_stall;
    logic [7:0]       o_red;
    logic [7:0]       o_green;
    logic [7:0]       o_blue;
    logic             o_line_done;
    logic             o_run_last;

    rgb_scoreboard sb = new();
    bit            tx_steady;
    bit            rx_steady;
    int unsigned   rx_taken;
    int unsigned   cycles;

    logic [7:0] dir_c [19] = '{8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0,
                               8'd128, 8'd128, 8'd0, 8'd255, 8'd16,
                               8'd255, 8'd0, 8'd0, 8'd255, 8'd128, 8'd16};
    logic [7:0] dir_y [19] = '{8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd16, 8'd235,
                               8'd16, 8'd235, 8'd128, 8'd128, 8'd240,
                               8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd240};

    ycbcr422_to_rgb dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_chroma      (i_chroma),
        .i_luma        (i_luma),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_line_done   (o_line_done),
        .o_run_last    (o_run_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("ycbcr422_to_rgb: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_pixel({o_red, o_green, o_blue, o_line_done, o_run_last});
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_word(logic [7:0] chroma, logic [7:0] luma);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_chroma <= chroma;
        i_luma   <= luma;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_word(chroma, luma);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.pixel_q.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
    endtask

    task automatic write_pairs(logic [11:0] value);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.pairs_cfg = value;
    endtask

    // receiver: random stall per pixel, two long hold-offs to back up the input
    initial begin
        int unsigned w;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_taken == 150 || rx_taken == 1200)
                w = HOLD_LEN;
            else
                w = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (w > 0) begin
                i_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            rx_taken++;
        end
    end

    initial begin
        logic [11:0] plan [N_PHASES];
        int unsigned n;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_valid       = 1'b0;
        i_chroma      = 8'd0;
        i_luma        = 8'd0;
        i_stall       = 1'b0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        rx_taken      = 0;
        cycles        = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes at the reset line length, then a zero length mid-line
        for (int k = 0; k < 19; k++) begin
            if (k == 13) write_pairs(12'd0);
            send_word(dir_c[k], dir_y[k]);
        end

        plan = '{12'd1, 12'd2048, 12'd3, 12'd4095, 12'd2, 12'd0,
                 12'($urandom_range(4, 40)), 12'd360, 12'd1, 12'd5,
                 12'($urandom_range(1, 2048)), 12'd2};
        for (int p = 0; p < N_PHASES; p++) begin
            write_pairs(plan[p]);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            n = 150 + $urandom_range(0, 20);
            for (int k = 0; k < n; k++)
                send_word(pick_byte(), pick_byte());
        end

        wait_idle();
        $display("%0d pixel words in, %0d pixels checked, %0d line ends", sb.words_in,
                 sb.pixels_out, sb.lines_done);
        $display("line lengths swept from 0 to 4095 pairs, with stalls and idle gaps");
        if (sb.errors == 0) begin
            $display("ycbcr422_to_rgb: match");
        end else begin
            $display("ycbcr422_to_rgb: mismatch");
        end
        $finish;
    end

endmodule
